@@ sv/actr_pkg.sv @@
// shared types, constants and round functions for the aes-128 counter-mode block
// no dependencies
package actr_pkg;

  localparam int ACTR_ROUNDS = 10;

  // register map of the configuration port
  typedef enum logic [7:0] {
    REG_KEY_LOW  = 8'd0,
    REG_KEY_HIGH = 8'd1,
    REG_IV_LOW   = 8'd2,
    REG_IV_HIGH  = 8'd3
  } actr_reg_t;

  localparam logic [7:0] ACTR_RCON0 = 8'h01;
  localparam logic [7:0] ACTR_POLY  = 8'h1B;
  localparam logic [4:0] ACTR_FULL_BLOCK = 5'd16;

  // item handed from front to back
  typedef struct packed {
    logic [127:0] ctr;
    logic [127:0] data;
    logic [15:0]  mask;
    logic [4:0]   nbytes;
  } actr_item_t;

  // finished result beat
  typedef struct packed {
    logic [63:0] high;
    logic [63:0] low;
    logic [4:0]  nbytes;
  } actr_res_t;

  localparam logic [7:0] ACTR_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] actr_xtime(input logic [7:0] b);
    actr_xtime = {b[6:0], 1'b0} ^ (b[7] ? ACTR_POLY : 8'h00);
  endfunction

  // sub bytes and shift rows; byte i of the state sits in bits 8i+7:8i
  function automatic logic [127:0] actr_sub_shift(input logic [127:0] s);
    logic [127:0] o;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        o[8*(4*c+r) +: 8] = ACTR_SBOX[s[8*(4*((c+r)%4)+r) +: 8]];
      end
    end
    actr_sub_shift = o;
  endfunction

  function automatic logic [127:0] actr_mix(input logic [127:0] s);
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3, all;
    o = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = s[32*c +: 8];
      a1  = s[32*c+8 +: 8];
      a2  = s[32*c+16 +: 8];
      a3  = s[32*c+24 +: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      o[32*c +: 8]    = a0 ^ all ^ actr_xtime(a0 ^ a1);
      o[32*c+8 +: 8]  = a1 ^ all ^ actr_xtime(a1 ^ a2);
      o[32*c+16 +: 8] = a2 ^ all ^ actr_xtime(a2 ^ a3);
      o[32*c+24 +: 8] = a3 ^ all ^ actr_xtime(a3 ^ a0);
    end
    actr_mix = o;
  endfunction

  // next round key from the previous one
  function automatic logic [127:0] actr_key_next(input logic [127:0] k,
                                                 input logic [7:0] rcon);
    logic [31:0] t;
    logic [127:0] o;
    t = {ACTR_SBOX[k[103:96]], ACTR_SBOX[k[127:120]],
         ACTR_SBOX[k[119:112]], ACTR_SBOX[k[111:104]] ^ rcon};
    o[31:0]   = k[31:0] ^ t;
    o[63:32]  = k[63:32] ^ o[31:0];
    o[95:64]  = k[95:64] ^ o[63:32];
    o[127:96] = k[127:96] ^ o[95:64];
    actr_key_next = o;
  endfunction

endpackage

@@ sv/actr_fifo.sv @@
// small show-ahead queue built from registers
// depends on nothing; DEPTH must be a power of two
module actr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == AW'(0) + (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  // pointer and fill count update
  always_comb begin
    wr_nxt  = do_push ? wr_r + AW'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + AW'(1) : rd_r;
    cnt_nxt = cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end
endmodule

@@ sv/actr_keyexp.sv @@
// round key expansion, one round key per cycle after any key write or reset
// depends on actr_pkg
module actr_keyexp
  import actr_pkg::*;
#(
  parameter int ROUNDS = ACTR_ROUNDS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      key_wr,
  input  logic [127:0]              key,
  output logic [ROUNDS:0][127:0]    rk,
  output logic                      kready
);
  localparam int CW = $clog2(ROUNDS + 1);

  logic [127:0]  rk_r [ROUNDS+1];
  logic [127:0]  prev_r, prev_nxt, knext;
  logic [7:0]    rcon_r, rcon_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          kready_r, kready_nxt, wr_en;

  assign knext  = actr_key_next(prev_r, rcon_r);
  assign kready = kready_r;

  always_comb begin
    for (int i = 0; i <= ROUNDS; i++) begin
      rk[i] = rk_r[i];
    end
  end

  // expansion sequencer
  always_comb begin
    kready_nxt = kready_r;
    cnt_nxt    = cnt_r;
    prev_nxt   = prev_r;
    rcon_nxt   = rcon_r;
    wr_en      = 1'b0;
    if (key_wr) begin
      kready_nxt = 1'b0;
      cnt_nxt    = '0;
    end else if (!kready_r) begin
      wr_en = 1'b1;
      if (cnt_r == '0) begin
        prev_nxt = key;
        rcon_nxt = ACTR_RCON0;
        cnt_nxt  = CW'(1);
      end else begin
        prev_nxt = knext;
        rcon_nxt = actr_xtime(rcon_r);
        if (cnt_r == CW'(ROUNDS)) begin
          kready_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kready_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      kready_r <= kready_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // key schedule storage
  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    rcon_r <= rcon_nxt;
    if (wr_en) begin
      rk_r[cnt_r] <= prev_nxt;
    end
  end
endmodule

@@ sv/actr_front.sv @@
// front end: accepts a beat, forms the counter, clamps the byte count, builds the mask
// depends on actr_pkg
module actr_front
  import actr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        kready,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_block_number,
  input  logic [63:0] in_data_low,
  input  logic [63:0] in_data_high,
  input  logic [4:0]  in_valid_bytes,
  input  logic [63:0] iv_low,
  input  logic [63:0] iv_high,
  input  logic        mid_full,
  output logic        mid_push,
  output actr_item_t  mid_item
);
  logic       v_r, v_nxt, accept;
  actr_item_t item_r, item_nxt;
  logic [4:0] n;

  assign mid_push = v_r && !mid_full;
  assign in_full  = !kready || (v_r && mid_full);
  assign accept   = in_push && !in_full;
  assign mid_item = item_r;

  // classify the incoming beat
  always_comb begin
    n = (in_valid_bytes > ACTR_FULL_BLOCK) ? ACTR_FULL_BLOCK : in_valid_bytes;
    item_nxt.ctr    = {iv_high, iv_low + in_block_number};
    item_nxt.data   = {in_data_high, in_data_low};
    item_nxt.nbytes = n;
    for (int i = 0; i < 16; i++) begin
      item_nxt.mask[i] = (5'(i) < n);
    end
    v_nxt = accept ? 1'b1 : (mid_push ? 1'b0 : v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end
endmodule

@@ sv/actr_back.sv @@
// back end: one aes round per pipeline stage, keystream xor and byte masking
// depends on actr_pkg
module actr_back
  import actr_pkg::*;
#(
  parameter int ROUNDS    = ACTR_ROUNDS,
  parameter int OUT_DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [ROUNDS:0][127:0] rk,
  input  logic                   mid_empty,
  input  actr_item_t             mid_item,
  output logic                   mid_pop,
  input  logic                   res_taken,
  output logic                   res_push,
  output actr_res_t              res,
  output logic [$clog2(OUT_DEPTH+1)-1:0] credit_cnt
);
  localparam int CRW = $clog2(OUT_DEPTH + 1);

  logic       v_r   [ROUNDS+1];
  logic [127:0] st_r [ROUNDS+1];
  actr_item_t side_r [ROUNDS+1];
  logic [CRW-1:0] cred_r, cred_nxt;
  logic [127:0] ks;

  // issue only with room reserved in the result queue
  assign mid_pop    = !mid_empty && (cred_r < CRW'(OUT_DEPTH));
  assign credit_cnt = cred_r;

  always_comb begin
    cred_nxt = cred_r + CRW'(mid_pop) - CRW'(res_taken);
  end

  // valid bits through the round pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
      for (int i = 0; i <= ROUNDS; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      cred_r <= cred_nxt;
      v_r[0] <= mid_pop;
      for (int i = 1; i <= ROUNDS; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // round stages: initial key add, full rounds, final round without mix
  always_ff @(posedge clk) begin
    st_r[0]   <= mid_item.ctr ^ rk[0];
    side_r[0] <= mid_item;
    for (int i = 1; i < ROUNDS; i++) begin
      st_r[i]   <= actr_mix(actr_sub_shift(st_r[i-1])) ^ rk[i];
      side_r[i] <= side_r[i-1];
    end
    st_r[ROUNDS]   <= actr_sub_shift(st_r[ROUNDS-1]) ^ rk[ROUNDS];
    side_r[ROUNDS] <= side_r[ROUNDS-1];
  end

  // keystream xor with masking of bytes past the count
  always_comb begin
    ks = st_r[ROUNDS] ^ side_r[ROUNDS].data;
    for (int i = 0; i < 16; i++) begin
      if (!side_r[ROUNDS].mask[i]) begin
        ks[8*i +: 8] = 8'h00;
      end
    end
    res.low    = ks[63:0];
    res.high   = ks[127:64];
    res.nbytes = side_r[ROUNDS].nbytes;
  end

  assign res_push = v_r[ROUNDS];
endmodule

@@ sv/aes128_ctr_block_crypt.sv @@
// AES-128 counter-mode block crypt. Each input beat carries one 16-byte block,
// its absolute block number and a valid byte count; the counter is the IV with
// the block number added to its low 64-bit lane (no carry into the high lane),
// and output bytes past the count read zero. After reset and after any write to
// a key register the round keys are expanded, during which in_full stays high.
// Once keys are ready a new block is accepted every cycle unless back-pressure
// from the result queue holds it; an accepted block passes the front register,
// the queue and 11 round stages before it is pushed into the result queue.
// depends on actr_pkg, actr_fifo, actr_keyexp, actr_front, actr_back
module aes128_ctr_block_crypt
  import actr_pkg::*;
#(
  parameter int ROUNDS = ACTR_ROUNDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [63:0] in_block_number,
  input  logic [63:0] in_data_low,
  input  logic [63:0] in_data_high,
  input  logic [4:0]  in_valid_bytes,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [63:0] out_low,
  output logic [63:0] out_high,
  output logic [4:0]  out_valid_bytes
);
  localparam int OUT_DEPTH = 1 << $clog2(ROUNDS + 4);
  localparam int CRW = $clog2(OUT_DEPTH + 1);

  logic [63:0] key_low_r, key_high_r, iv_low_r, iv_high_r;
  logic        cfg_wr, key_wr, kready;
  logic [ROUNDS:0][127:0] rk;
  logic        mid_full, mid_empty, mid_push, mid_pop;
  actr_item_t  mid_in, mid_out;
  logic        res_push, res_taken, res_full;
  actr_res_t   res_in, res_out;
  logic [CRW-1:0] credit_cnt;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign key_wr    = cfg_wr && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      iv_low_r   <= '0;
      iv_high_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_IV_LOW:   iv_low_r   <= cfg_data;
        REG_IV_HIGH:  iv_high_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  actr_keyexp #(.ROUNDS(ROUNDS)) u_keyexp (
    .clk(clk), .rst_n(rst_n), .key_wr(key_wr), .key({key_high_r, key_low_r}),
    .rk(rk), .kready(kready)
  );

  actr_front u_front (
    .clk(clk), .rst_n(rst_n), .kready(kready),
    .in_push(in_push), .in_full(in_full),
    .in_block_number(in_block_number), .in_data_low(in_data_low),
    .in_data_high(in_data_high), .in_valid_bytes(in_valid_bytes),
    .iv_low(iv_low_r), .iv_high(iv_high_r),
    .mid_full(mid_full), .mid_push(mid_push), .mid_item(mid_in)
  );

  // queue between front and back
  actr_fifo #(.WIDTH($bits(actr_item_t)), .DEPTH(2)) u_mid_q (
    .clk(clk), .rst_n(rst_n), .push(mid_push), .din(mid_in), .pop(mid_pop),
    .dout(mid_out), .full(mid_full), .empty(mid_empty)
  );

  actr_back #(.ROUNDS(ROUNDS), .OUT_DEPTH(OUT_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .rk(rk), .mid_empty(mid_empty), .mid_item(mid_out),
    .mid_pop(mid_pop), .res_taken(res_taken), .res_push(res_push), .res(res_in),
    .credit_cnt(credit_cnt)
  );

  // result queue, sized to hold every block in flight
  actr_fifo #(.WIDTH($bits(actr_res_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk(clk), .rst_n(rst_n), .push(res_push), .din(res_in), .pop(out_pop),
    .dout(res_out), .full(res_full), .empty(out_empty)
  );

  assign res_taken       = out_pop && !out_empty;
  assign out_low         = res_out.low;
  assign out_high        = res_out.high;
  assign out_valid_bytes = res_out.nbytes;

  // checks
  a_no_res_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full) else $error("result beat pushed into full queue");

  a_accept_keys_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> kready) else $error("beat accepted before key expansion");

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_cnt <= CRW'(OUT_DEPTH)) else $error("credit count out of range");

  a_key_wr_clears: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr |=> !kready) else $error("key write did not restart expansion");
endmodule

@@ sim/aes128_ctr_block_crypt_test.sv @@
// self-checking testbench for aes128_ctr_block_crypt: directed, random and back-pressure runs
// checked against an AES-128 counter-mode predictor; depends on actr_pkg and the block RTL
module aes128_ctr_block_crypt_test;
  import actr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [7:0] REG_UNMAPPED = 8'd4;
  localparam logic [7:0] REG_TOP = 8'd255;

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
    logic [4:0]  nbytes;
  } cipher_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [63:0] in_block_number = '0;
  logic [63:0] in_data_low = '0;
  logic [63:0] in_data_high = '0;
  logic [4:0]  in_valid_bytes = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [63:0] out_low;
  logic [63:0] out_high;
  logic [4:0]  out_valid_bytes;

  aes128_ctr_block_crypt i_dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [63:0]  key_lo, key_hi, iv_lo, iv_hi;
  logic [127:0] round_keys [0:10];
  bit           keys_stale;
  cipher_beat_t pending_cipher [$];
  int           err_count = 0;
  int           blocks_sent = 0;
  int           beats_checked = 0;
  int           cycle_count = 0;
  bit           quiet_rx = 0;
  bit           quiet_tx = 0;
  int           rx_hold_req = 0;

  localparam logic [7:0] SBOX_T [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [127:0] sub_and_shift(input logic [127:0] st);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        o[8*(4*c+r) +: 8] = SBOX_T[st[8*(4*((c+r)%4)+r) +: 8]];
    return o;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] st);
    logic [127:0] o;
    logic [7:0] b0, b1, b2, b3, sum;
    for (int c = 0; c < 4; c++) begin
      b0 = st[32*c +: 8];
      b1 = st[32*c+8 +: 8];
      b2 = st[32*c+16 +: 8];
      b3 = st[32*c+24 +: 8];
      sum = b0 ^ b1 ^ b2 ^ b3;
      o[32*c +: 8]    = b0 ^ sum ^ gf_double(b0 ^ b1);
      o[32*c+8 +: 8]  = b1 ^ sum ^ gf_double(b1 ^ b2);
      o[32*c+16 +: 8] = b2 ^ sum ^ gf_double(b2 ^ b3);
      o[32*c+24 +: 8] = b3 ^ sum ^ gf_double(b3 ^ b0);
    end
    return o;
  endfunction

  // key schedule on the byte array, then packed per round
  task automatic expand_round_keys();
    logic [7:0] w [176];
    logic [7:0] t [4];
    logic [7:0] rc, keep;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) begin
      w[i] = key_lo[8*i +: 8];
      w[i+8] = key_hi[8*i +: 8];
    end
    for (int i = 4; i < 44; i++) begin
      for (int r = 0; r < 4; r++) t[r] = w[4*(i-1)+r];
      if (i % 4 == 0) begin
        keep = t[0];
        t[0] = SBOX_T[t[1]] ^ rc;
        t[1] = SBOX_T[t[2]];
        t[2] = SBOX_T[t[3]];
        t[3] = SBOX_T[keep];
        rc = gf_double(rc);
      end
      for (int r = 0; r < 4; r++) w[4*i+r] = w[4*(i-4)+r] ^ t[r];
    end
    for (int r = 0; r <= 10; r++)
      for (int j = 0; j < 16; j++) round_keys[r][8*j +: 8] = w[16*r+j];
    keys_stale = 0;
  endtask

  // expected ciphertext beat for one accepted block
  task automatic predict_cipher(input logic [63:0] bn, input logic [63:0] dl,
                                input logic [63:0] dh, input logic [4:0] vb);
    logic [127:0] st, d;
    logic [4:0] n;
    cipher_beat_t b;
    if (keys_stale) expand_round_keys();
    n = (vb > 5'd16) ? 5'd16 : vb;
    st = {iv_hi, iv_lo + bn} ^ round_keys[0];
    for (int r = 1; r < 10; r++) st = mix_cols(sub_and_shift(st)) ^ round_keys[r];
    st = sub_and_shift(st) ^ round_keys[10];
    d = {dh, dl} ^ st;
    for (int i = 0; i < 16; i++) if (i >= n) d[8*i +: 8] = 8'h00;
    b.low = d[63:0];
    b.high = d[127:64];
    b.nbytes = n;
    pending_cipher.push_back(b);
  endtask

  // result checker
  always @(posedge clk) begin
    cipher_beat_t e;
    if (rst_n && !out_empty && out_pop) begin
      if (pending_cipher.size() == 0) begin
        $error("unexpected result beat low=%h high=%h", out_low, out_high);
        err_count++;
      end else begin
        e = pending_cipher.pop_front();
        beats_checked++;
        if (out_low !== e.low) begin
          $error("out_low exp %h got %h", e.low, out_low);
          err_count++;
        end
        if (out_high !== e.high) begin
          $error("out_high exp %h got %h", e.high, out_high);
          err_count++;
        end
        if (out_valid_bytes !== e.nbytes) begin
          $error("out_valid_bytes exp %0d got %0d", e.nbytes, out_valid_bytes);
          err_count++;
        end
      end
    end
  end

  // receiver: random pops, plus a long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall > 0) begin
        out_pop = 1'b0;
        stall--;
      end else if (quiet_rx) begin
        out_pop = 1'b1;
      end else begin
        stall = idle_len();
        out_pop = (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one block beat; returns at a falling edge, with in_push still high only when no gap follows
  task automatic send_block(input logic [63:0] bn, input logic [63:0] dl,
                            input logic [63:0] dh, input logic [4:0] vb);
    int gap;
    in_push = 1'b1;
    in_block_number = bn;
    in_data_low = dl;
    in_data_high = dh;
    in_valid_bytes = vb;
    while (in_full) @(negedge clk);
    predict_cipher(bn, dl, dh, vb);
    blocks_sent++;
    @(negedge clk);
    gap = quiet_tx ? 0 : idle_len();
    if (gap > 0) begin
      in_push = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // wait until every expected beat is out, then let the pipeline settle
  task automatic drain();
    in_push = 1'b0;
    while (pending_cipher.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    while (!cfg_ready) @(negedge clk);
    case (idx)
      REG_KEY_LOW:  begin key_lo = val; keys_stale = 1; end
      REG_KEY_HIGH: begin key_hi = val; keys_stale = 1; end
      REG_IV_LOW:   iv_lo = val;
      REG_IV_HIGH:  iv_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(input logic [63:0] kl, input logic [63:0] kh,
                         input logic [63:0] il, input logic [63:0] ih);
    drain();
    write_reg(REG_KEY_LOW, kl);
    write_reg(REG_KEY_HIGH, kh);
    write_reg(REG_IV_LOW, il);
    write_reg(REG_IV_HIGH, ih);
  endtask

  // reset config first, then extremes of fields and special cases
  task automatic test_directed();
    send_block('0, '0, '0, 5'd16);
    send_block('1, '1, '1, 5'd16);
    send_block(64'd1, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd1);
    set_all(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '1, 64'h8000000000000001);
    // counter wrap of the low lane
    send_block(64'd0, rand64(), rand64(), 5'd16);
    send_block(64'd1, rand64(), rand64(), 5'd16);
    send_block(64'd2, rand64(), rand64(), 5'd15);
    send_block('1, rand64(), rand64(), 5'd8);
    // zero count, saturated counts, tails
    send_block(64'd5, '1, '1, 5'd0);
    send_block(64'd6, '1, '1, 5'd17);
    send_block(64'd7, '1, '1, 5'd31);
    send_block(64'd8, '1, '1, 5'd7);
    send_block(64'd9, '1, '1, 5'd9);
    // unmapped register indexes must be ignored
    drain();
    write_reg(REG_UNMAPPED, '1);
    write_reg(REG_TOP, '1);
    send_block(64'd10, rand64(), rand64(), 5'd16);
    set_all('1, '1, '0, '1);
    send_block(64'h8000000000000000, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd16);
    send_block(64'h7fffffffffffffff, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd16);
    // key change alone forces re-expansion
    drain();
    write_reg(REG_KEY_HIGH, 64'h1);
    send_block(64'd3, rand64(), rand64(), 5'd16);
    drain();
    write_reg(REG_KEY_LOW, 64'h2);
    send_block(64'd4, rand64(), rand64(), 5'd12);
  endtask

  // streams of consecutive blocks with a tail, plus scattered odd beats
  task automatic test_random(input int count);
    logic [63:0] bn;
    logic [4:0] vb;
    int run, sent;
    sent = 0;
    while (sent < count) begin
      bn = ($urandom_range(0, 3) == 0) ? ('1 - $urandom_range(0, 4)) : rand64();
      run = $urandom_range(1, 24);
      for (int i = 0; i < run && sent < count; i++) begin
        if ($urandom_range(0, 9) == 0) vb = 5'($urandom_range(0, 31));
        else if (i == run - 1) vb = 5'($urandom_range(1, 16));
        else vb = 5'd16;
        send_block(bn, rand64(), rand64(), vb);
        bn = bn + 64'd1;
        sent++;
      end
    end
  endtask

  // several settings, extremes and random
  task automatic test_config_sweep();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_all('0, '0, '0, '0);
        1: set_all('1, '1, '1, '1);
        default: set_all(rand64(), rand64(), rand64(), rand64());
      endcase
      quiet_tx = (p == 3);
      quiet_rx = (p == 3);
      test_random(80);
    end
    quiet_tx = 0;
    quiet_rx = 0;
  endtask

  // receiver holds off while the sender keeps offering, block fills up
  task automatic test_backpressure();
    drain();
    rx_hold_req = 300;
    quiet_tx = 1;
    test_random(60);
    quiet_tx = 0;
  endtask

  initial begin
    key_lo = '0;
    key_hi = '0;
    iv_lo = '0;
    iv_hi = '0;
    keys_stale = 1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    drain();
    $display("covered %0d blocks, %0d result beats checked", blocks_sent, beats_checked);
    $display("key/iv extremes, counter wrap, tail and saturated counts, back-pressure");
    if (err_count == 0 && pending_cipher.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/actr_pkg.sv
sv/actr_fifo.sv
sv/actr_keyexp.sv
sv/actr_front.sv
sv/actr_back.sv
sv/aes128_ctr_block_crypt.sv
sim/aes128_ctr_block_crypt_test.sv
